// ===== rtl/core/differential_drive_odometry_assert.svh =====
// ---------------------------------------------------------------------------
// Odometry assertion macros
// Shared concurrent assertion forms for the odometry RTL.
// ---------------------------------------------------------------------------
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_ASSERT_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DDO_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("odometry assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define DDO_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("odometry assertion failed");

`endif

// ===== rtl/core/ddo_pkg.sv =====
// ---------------------------------------------------------------------------
// Odometry package
// Request types, register indexes, fixed constants and the CORDIC table.
// ---------------------------------------------------------------------------
package ddo_pkg;

  typedef struct packed {
    logic signed [31:0] left_count;
    logic signed [31:0] right_count;
  } ddo_in_t;

  typedef struct packed {
    logic signed [31:0] x_position;
    logic signed [31:0] y_position;
    logic        [31:0] heading;
    logic signed [31:0] quat_z;
    logic signed [31:0] quat_w;
  } ddo_out_t;

  typedef struct packed {
    logic signed [31:0] cos_v;
    logic signed [31:0] sin_v;
  } ddo_trig_t;

  localparam int unsigned CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_DIST_PER_TICK = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_INV_WHEEL_BASE = 1'd1;

  localparam logic [31:0] DIST_PER_TICK_RST = 32'd278294;
  localparam logic [31:0] INV_WHEEL_BASE_RST = 32'd104857600;
  localparam logic [29:0] ANGLE_SCALE = 30'd683565276;
  localparam logic [29:0] CORDIC_GAIN_INV = 30'd652032874;
  localparam int unsigned CORDIC_STEPS = 24;
  localparam logic [4:0] CORDIC_LAST = 5'(CORDIC_STEPS - 1);

  function automatic logic [29:0] cordic_atan(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/ddo_cordic.sv =====
// ---------------------------------------------------------------------------
// Iterative CORDIC sine and cosine
// One shift-add stage reused for 24 rotations of a binary angle.
// ---------------------------------------------------------------------------
module ddo_cordic
  import ddo_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] angle,
  output logic        done,
  output ddo_trig_t   trig
);

  logic               busy_r;
  logic               done_r;
  logic [4:0]         iter_r;
  logic [1:0]         quad_r;
  logic signed [33:0] x_r;
  logic signed [33:0] y_r;
  logic signed [32:0] z_r;
  logic [1:0]         quad_nxt;
  logic [31:0]        z_start;
  logic signed [33:0] x_sh;
  logic signed [33:0] y_sh;
  logic signed [32:0] atan_v;
  logic signed [31:0] x_cl;
  logic signed [31:0] y_cl;

  assign quad_nxt = 2'((angle + 32'h2000_0000) >> 30);
  assign z_start  = angle - {quad_nxt, 30'd0};
  assign x_sh     = y_r >>> iter_r;
  assign y_sh     = x_r >>> iter_r;
  assign atan_v   = $signed({3'd0, cordic_atan(iter_r)});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      iter_r <= '0;
    end else begin
      done_r <= busy_r && !start && (iter_r == CORDIC_LAST);
      if (start) begin
        busy_r <= 1'b1;
        iter_r <= '0;
      end else if (busy_r) begin
        if (iter_r == CORDIC_LAST) begin
          busy_r <= 1'b0;
        end
        iter_r <= iter_r + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quad_r <= quad_nxt;
      x_r    <= $signed({4'd0, CORDIC_GAIN_INV});
      y_r    <= '0;
      z_r    <= 33'($signed(z_start));
    end else if (busy_r) begin
      if (!z_r[32]) begin
        x_r <= x_r - x_sh;
        y_r <= y_r + y_sh;
        z_r <= z_r - atan_v;
      end else begin
        x_r <= x_r + x_sh;
        y_r <= y_r - y_sh;
        z_r <= z_r + atan_v;
      end
    end
  end

  always_comb begin
    if (x_r > 34'sd1073741824) begin
      x_cl = 32'sd1073741824;
    end else if (x_r < -34'sd1073741824) begin
      x_cl = -32'sd1073741824;
    end else begin
      x_cl = 32'(x_r);
    end
    if (y_r > 34'sd1073741824) begin
      y_cl = 32'sd1073741824;
    end else if (y_r < -34'sd1073741824) begin
      y_cl = -32'sd1073741824;
    end else begin
      y_cl = 32'(y_r);
    end
    case (quad_r)
      2'd0: begin
        trig.cos_v = x_cl;
        trig.sin_v = y_cl;
      end
      2'd1: begin
        trig.cos_v = -y_cl;
        trig.sin_v = x_cl;
      end
      2'd2: begin
        trig.cos_v = -x_cl;
        trig.sin_v = -y_cl;
      end
      default: begin
        trig.cos_v = y_cl;
        trig.sin_v = -x_cl;
      end
    endcase
  end

  assign done = done_r;

endmodule

// ===== rtl/core/differential_drive_odometry.sv =====
// ---------------------------------------------------------------------------
// Differential drive wheel odometry
// Integrates encoder counts into a saturating pose with a yaw quaternion.
// ---------------------------------------------------------------------------
// Channel   Direction  Handshake          Payload
// in_       input      in_valid/in_stall  ddo_in_t (left and right counts)
// out_      output     out_valid/out_stall ddo_out_t (pose and quaternion)
// cfg_      input      cfg_we             cfg_index, cfg_data
//
// One request passes from acceptance to a valid result through ten steps of
// the shared multiplier, two runs of the 24-step CORDIC unit and three steps
// for the position update. No new request is taken while one is in flight.
// Reset is synchronous, clears the pose and previous counts and restores
// the registers to their reset values. A stalled result holds the block,
// and the next request is taken once it is delivered.
// ---------------------------------------------------------------------------
`include "differential_drive_odometry_assert.svh"

module differential_drive_odometry
  import ddo_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  ddo_in_t                in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output ddo_out_t               out_data,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]            cfg_data
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_ROT1 = 6'b000100,
    S_ADV  = 6'b001000,
    S_ROT2 = 6'b010000,
    S_OUT  = 6'b100000
  } ddo_state_t;

  ddo_state_t             state_r;
  logic [3:0]             step_r;
  logic [31:0]            dpt_r;
  logic [31:0]            iwb_r;
  logic [COUNT_WIDTH-1:0] prev_l_r;
  logic [COUNT_WIDTH-1:0] prev_r_r;
  logic signed [31:0]     x_r;
  logic signed [31:0]     y_r;
  logic [31:0]            heading_r;
  logic signed [34:0]     dlt_l_r;
  logic signed [34:0]     dlt_r_r;
  logic signed [56:0]     dist_l_r;
  logic signed [56:0]     dist_r_r;
  logic signed [33:0]     centre_r;
  logic signed [57:0]     ud_r;
  logic [56:0]            acc_r;
  logic [56:0]            rad_r;
  logic [31:0]            dbam_r;
  ddo_trig_t              trig_r;
  ddo_out_t               out_r;
  logic signed [67:0]     prod_r;

  logic [COUNT_WIDTH-1:0] diff_l;
  logic [COUNT_WIDTH-1:0] diff_r;
  logic signed [34:0]     mul_a;
  logic signed [32:0]     mul_b;
  logic signed [57:0]     sum_w;
  logic signed [57:0]     half_w;
  logic signed [33:0]     centre_nxt;
  logic [56:0]            p_w;
  logic [31:0]            heading_nxt;
  logic signed [67:0]     round_w;
  logic signed [33:0]     adv_x;
  logic signed [33:0]     adv_y;
  logic signed [31:0]     x_nxt;
  logic signed [31:0]     y_nxt;
  logic                   in_acc;
  logic                   cd_start;
  logic [31:0]            cd_angle;
  logic                   cd_done;
  ddo_trig_t              cd_trig;

  assign in_acc      = in_valid && !in_stall;
  assign in_stall    = (state_r != S_IDLE);
  assign out_valid   = (state_r == S_OUT);
  assign out_data    = out_r;
  assign diff_l      = in_data.left_count[COUNT_WIDTH-1:0] - prev_l_r;
  assign diff_r      = in_data.right_count[COUNT_WIDTH-1:0] - prev_r_r;
  assign sum_w       = 58'(dist_l_r) + 58'(dist_r_r);
  assign half_w      = sum_w >>> 1;
  assign p_w         = acc_r + {prod_r[24:0], 32'd0};
  assign heading_nxt = heading_r + dbam_r;
  assign round_w     = prod_r + 68'sd137438953472;
  assign adv_x       = 34'(x_r) + 34'($signed(round_w[67:38]));
  assign adv_y       = 34'(y_r) + 34'($signed(round_w[67:38]));

  always_comb begin
    if (half_w > 58'sd4294967296) begin
      centre_nxt = 34'sd4294967296;
    end else if (half_w < -58'sd4294967296) begin
      centre_nxt = -34'sd4294967296;
    end else begin
      centre_nxt = 34'(half_w);
    end
    if (adv_x > 34'sd2147483647) begin
      x_nxt = 32'sh7fff_ffff;
    end else if (adv_x < -34'sd2147483648) begin
      x_nxt = 32'sh8000_0000;
    end else begin
      x_nxt = 32'(adv_x);
    end
    if (adv_y > 34'sd2147483647) begin
      y_nxt = 32'sh7fff_ffff;
    end else if (adv_y < -34'sd2147483648) begin
      y_nxt = 32'sh8000_0000;
    end else begin
      y_nxt = 32'(adv_y);
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == S_MUL) begin
      case (step_r)
        4'd0: begin
          mul_a = dlt_l_r;
          mul_b = $signed({1'b0, dpt_r});
        end
        4'd1: begin
          mul_a = dlt_r_r;
          mul_b = $signed({1'b0, dpt_r});
        end
        4'd4: begin
          mul_a = 35'($signed(ud_r[57:32]));
          mul_b = $signed({1'b0, iwb_r});
        end
        4'd5: begin
          mul_a = $signed({3'd0, ud_r[31:0]});
          mul_b = $signed({1'b0, iwb_r});
        end
        4'd7: begin
          mul_a = $signed({3'd0, rad_r[31:0]});
          mul_b = $signed({3'd0, ANGLE_SCALE});
        end
        4'd8: begin
          mul_a = $signed({10'd0, rad_r[56:32]});
          mul_b = $signed({3'd0, ANGLE_SCALE});
        end
        default: begin
          mul_a = '0;
          mul_b = '0;
        end
      endcase
    end else if (state_r == S_ADV) begin
      mul_a = 35'(centre_r);
      if (step_r == 4'd0) begin
        mul_b = 33'(trig_r.cos_v);
      end else begin
        mul_b = 33'(trig_r.sin_v);
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  always_comb begin
    cd_start = 1'b0;
    cd_angle = {1'b0, heading_nxt[31:1]};
    if (state_r == S_MUL && step_r == 4'd9) begin
      cd_start = 1'b1;
      cd_angle = heading_r + p_w[56:25];
    end else if (state_r == S_ADV && step_r == 4'd2) begin
      cd_start = 1'b1;
    end
  end

  ddo_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cd_start),
    .angle (cd_angle),
    .done  (cd_done),
    .trig  (cd_trig)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dpt_r <= DIST_PER_TICK_RST;
      iwb_r <= INV_WHEEL_BASE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DIST_PER_TICK:  dpt_r <= cfg_data;
        REG_INV_WHEEL_BASE: iwb_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      step_r    <= '0;
      prev_l_r  <= '0;
      prev_r_r  <= '0;
      x_r       <= '0;
      y_r       <= '0;
      heading_r <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            prev_l_r <= in_data.left_count[COUNT_WIDTH-1:0];
            prev_r_r <= in_data.right_count[COUNT_WIDTH-1:0];
            step_r   <= '0;
            state_r  <= S_MUL;
          end
        end
        S_MUL: begin
          if (step_r == 4'd9) begin
            step_r  <= '0;
            state_r <= S_ROT1;
          end else begin
            step_r <= step_r + 4'd1;
          end
        end
        S_ROT1: begin
          if (cd_done) begin
            step_r  <= '0;
            state_r <= S_ADV;
          end
        end
        S_ADV: begin
          step_r <= step_r + 4'd1;
          if (step_r == 4'd1) begin
            x_r <= x_nxt;
          end
          if (step_r == 4'd2) begin
            y_r       <= y_nxt;
            heading_r <= heading_nxt;
            state_r   <= S_ROT2;
          end
        end
        S_ROT2: begin
          if (cd_done) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      dlt_l_r <= 35'($signed(diff_l));
      dlt_r_r <= 35'($signed(diff_r));
    end
    if (state_r == S_MUL) begin
      case (step_r)
        4'd1: dist_l_r <= prod_r[64:8];
        4'd2: dist_r_r <= prod_r[64:8];
        4'd3: begin
          centre_r <= centre_nxt;
          ud_r     <= 58'(dist_r_r) - 58'(dist_l_r);
        end
        4'd5: acc_r <= prod_r[56:0];
        4'd6: rad_r <= {acc_r[48:0], 8'd0} + 57'(prod_r[63:24]);
        4'd8: acc_r <= prod_r[56:0];
        4'd9: dbam_r <= p_w[55:24];
        default: ;
      endcase
    end
    if (state_r == S_ROT1 && cd_done) begin
      trig_r <= cd_trig;
    end
    if (state_r == S_ROT2 && cd_done) begin
      out_r.x_position <= x_r;
      out_r.y_position <= y_r;
      out_r.heading    <= heading_r;
      out_r.quat_z     <= cd_trig.sin_v;
      out_r.quat_w     <= cd_trig.cos_v;
    end
  end

  `DDO_ASSERT_SAME(a_no_take_while_out, clk, rst_n, out_valid, in_stall)
  `DDO_ASSERT_NEXT(a_accept_starts, clk, rst_n, in_acc, (state_r == S_MUL) && (step_r == 4'd0))
  `DDO_ASSERT_SAME(a_done_in_rot, clk, rst_n, cd_done, (state_r == S_ROT1) || (state_r == S_ROT2))
  `DDO_ASSERT_NEXT(a_out_holds, clk, rst_n, out_valid && out_stall, out_valid)

endmodule

// ===== bench/differential_drive_odometry_checker.sv =====
// ---------------------------------------------------------------------------
// Odometry checker
// Watches the request, result and register ports of the odometry block,
// predicts each pose and quaternion in fixed point, and compares the results
// in order, field by field.
// ---------------------------------------------------------------------------
module differential_drive_odometry_checker
  import ddo_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  ddo_in_t                in_data,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  ddo_out_t               out_data,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]            cfg_data,
  output int                     errors,
  output int                     pending
);

  localparam logic signed [63:0] ARCTAN [24] = '{
    64'sd536870912, 64'sd316933406, 64'sd167458907, 64'sd85004756, 64'sd42667331,
    64'sd21354465, 64'sd10679838, 64'sd5340245, 64'sd2670163, 64'sd1335087,
    64'sd667544, 64'sd333772, 64'sd166886, 64'sd83443, 64'sd41722, 64'sd20861,
    64'sd10430, 64'sd5215, 64'sd2608, 64'sd1304, 64'sd652, 64'sd326, 64'sd163,
    64'sd81
  };
  localparam logic signed [63:0] UNIT = 64'sd1073741824;
  localparam logic signed [63:0] TRAVEL_MAX = 64'sd4294967296;

  logic [31:0] tick_dist;
  logic [31:0] inv_base;
  logic [31:0] last_left;
  logic [31:0] last_right;
  logic [31:0] pos_x;
  logic [31:0] pos_y;
  logic [31:0] yaw;
  ddo_out_t    expected_poses[$];

  function automatic ddo_trig_t rotate_unit(input logic [31:0] phi);
    logic [1:0]         q;
    logic [31:0]        zr;
    logic signed [63:0] x, y, z, nx;
    ddo_trig_t          r;
    q = 2'((phi + 32'h2000_0000) >> 30);
    zr = phi - {q, 30'd0};
    z = {{32{zr[31]}}, zr};
    x = 64'sd652032874;
    y = 0;
    for (int i = 0; i < 24; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - ARCTAN[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + ARCTAN[i];
      end
      x = nx;
    end
    x = (x > UNIT) ? UNIT : ((x < -UNIT) ? -UNIT : x);
    y = (y > UNIT) ? UNIT : ((y < -UNIT) ? -UNIT : y);
    case (q)
      2'd0: begin r.cos_v = 32'(x); r.sin_v = 32'(y); end
      2'd1: begin r.cos_v = 32'(-y); r.sin_v = 32'(x); end
      2'd2: begin r.cos_v = 32'(-x); r.sin_v = 32'(-y); end
      default: begin r.cos_v = 32'(y); r.sin_v = 32'(-x); end
    endcase
    return r;
  endfunction

  function automatic logic [31:0] move_axis(input logic [31:0] pos,
                                            input logic signed [63:0] travel,
                                            input logic signed [31:0] factor);
    logic signed [63:0] prod, v;
    prod = travel * 64'(factor);
    v = 64'($signed(pos)) + ((prod + (64'sd1 <<< 37)) >>> 38);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  function automatic ddo_out_t integrate_pose(input ddo_in_t req);
    logic signed [63:0] dl, dr, wl, wr, centre;
    logic [63:0]        diff, hi, rad, p;
    logic [31:0]        dl32, dr32, phi;
    ddo_trig_t          t;
    ddo_out_t           o;
    dl32 = req.left_count - last_left;
    dr32 = req.right_count - last_right;
    dl = {{32{dl32[31]}}, dl32};
    dr = {{32{dr32[31]}}, dr32};
    wl = $signed(64'(dl * {32'd0, tick_dist})) >>> 8;
    wr = $signed(64'(dr * {32'd0, tick_dist})) >>> 8;
    centre = (wl + wr) >>> 1;
    diff = wr - wl;
    hi = $signed(diff) >>> 32;
    rad = ((hi * {32'd0, inv_base}) << 8) + (({32'd0, diff[31:0]} * {32'd0, inv_base}) >> 24);
    p = rad * 64'd683565276;
    phi = yaw + p[56:25];
    last_left = req.left_count;
    last_right = req.right_count;
    if (centre > TRAVEL_MAX) centre = TRAVEL_MAX;
    if (centre < -TRAVEL_MAX) centre = -TRAVEL_MAX;
    t = rotate_unit(phi);
    pos_x = move_axis(pos_x, centre, t.cos_v);
    pos_y = move_axis(pos_y, centre, t.sin_v);
    yaw = yaw + p[55:24];
    t = rotate_unit(yaw >> 1);
    o.x_position = pos_x;
    o.y_position = pos_y;
    o.heading = yaw;
    o.quat_z = t.sin_v;
    o.quat_w = t.cos_v;
    return o;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  initial begin
    errors = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    ddo_out_t want;
    if (!rst_n) begin
      tick_dist = DIST_PER_TICK_RST;
      inv_base = INV_WHEEL_BASE_RST;
      last_left = 0;
      last_right = 0;
      pos_x = 0;
      pos_y = 0;
      yaw = 0;
      expected_poses.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_DIST_PER_TICK) tick_dist = cfg_data;
        else if (cfg_index == REG_INV_WHEEL_BASE) inv_base = cfg_data;
      end
      if (in_valid && !in_stall) expected_poses.push_back(integrate_pose(in_data));
      if (out_valid && !out_stall) begin
        if (expected_poses.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
        end else begin
          want = expected_poses.pop_front();
          check_field("x_position", want.x_position, out_data.x_position);
          check_field("y_position", want.y_position, out_data.y_position);
          check_field("heading", want.heading, out_data.heading);
          check_field("quat_z", want.quat_z, out_data.quat_z);
          check_field("quat_w", want.quat_w, out_data.quat_w);
        end
      end
    end
    pending = expected_poses.size();
  end

endmodule

// ===== bench/differential_drive_odometry_tb.sv =====
// ---------------------------------------------------------------------------
// Odometry testbench
// Drives encoder count requests and register writes into the odometry block
// under several idle and stall patterns; a checker alongside predicts and
// compares every result.
// ---------------------------------------------------------------------------
module differential_drive_odometry_tb;
  import ddo_pkg::*;

  localparam int CYCLE_LIMIT = 1500000;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  ddo_in_t                in_data = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  ddo_out_t               out_data;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_DIST_PER_TICK;
  logic [31:0]            cfg_data = '0;
  int                     errors;
  int                     pending;
  int                     cycles = 0;
  int                     idle_pct = 0;
  int                     stall_pct = 0;
  logic                   in_taken = 1'b0;
  logic [31:0]            count_l = 0;
  logic [31:0]            count_r = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  differential_drive_odometry u_top (.*);

  differential_drive_odometry_checker u_checker (.*);

  always @(posedge clk) begin
    in_taken <= in_valid && !in_stall && rst_n;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(negedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  task automatic send_counts(input logic [31:0] l, input logic [31:0] r);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= {l, r};
    count_l = l;
    count_r = r;
    do @(negedge clk); while (!in_taken);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] next_count(input logic [31:0] c);
    case ($urandom_range(9))
      0, 1, 2, 3: return c + 32'($signed($urandom_range(2000)) - 1000);
      4, 5, 6:    return c + 32'($signed($urandom_range(2000000)) - 1000000);
      7:          return c + $urandom;
      default:    return $urandom;
    endcase
  endfunction

  task automatic random_phase(input int n, input int idle, input int stall);
    idle_pct = idle;
    stall_pct = stall;
    repeat (n) begin
      if ($urandom_range(3) == 0) send_counts(next_count(count_l), next_count(count_r));
      else begin
        logic [31:0] step;
        step = 32'($signed($urandom_range(4000)) - 2000);
        send_counts(count_l + step, count_r + step + 32'($urandom_range(20)) - 32'd10);
      end
    end
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_counts(32'd0, 32'd0);
    send_counts(32'd1000, 32'd1000);
    send_counts(32'd1000, 32'd5000);
    send_counts(32'd0, 32'd2000);
    send_counts(32'h7fff_ffff, 32'h7fff_ffff);
    send_counts(32'h8000_0000, 32'h8000_0000);
    send_counts(32'hffff_ffff, 32'h0000_0000);
    send_counts(32'h0000_0005, 32'hffff_fff0);
    send_counts(32'h8000_0000, 32'h7fff_ffff);
    send_counts(32'h7fff_ffff, 32'h8000_0000);
    send_counts(32'hffff_ffff, 32'hffff_ffff);

    write_reg(REG_DIST_PER_TICK, 32'hffff_ffff);
    write_reg(REG_INV_WHEEL_BASE, 32'hffff_ffff);
    send_counts(32'h7fff_ffff, 32'h7fff_ffff);
    send_counts(32'hffff_fffe, 32'hffff_fffe);
    send_counts(32'h7fff_fffd, 32'h8000_0000);
    for (int i = 0; i < 10; i++) send_counts(count_l + 32'h7fff_ffff, count_r + 32'h7fff_ffff);
    random_phase(150, 0, 0);

    write_reg(REG_DIST_PER_TICK, 32'd0);
    random_phase(100, 51, 0);

    write_reg(REG_DIST_PER_TICK, 32'h0100_0000);
    write_reg(REG_INV_WHEEL_BASE, 32'd0);
    random_phase(150, 0, 51);

    write_reg(REG_DIST_PER_TICK, DIST_PER_TICK_RST);
    write_reg(REG_INV_WHEEL_BASE, INV_WHEEL_BASE_RST);
    random_phase(200, 18, 18);

    write_reg(REG_DIST_PER_TICK, $urandom);
    write_reg(REG_INV_WHEEL_BASE, $urandom);
    random_phase(200, 51, 0);

    write_reg(REG_DIST_PER_TICK, $urandom_range(32'h0010_0000));
    write_reg(REG_INV_WHEEL_BASE, $urandom);
    random_phase(200, 0, 51);

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
